>>> rtl/sapq_pkg.sv
// Shared types and constants of the sorted-array priority queue.
package sapq_pkg;

  // Queue depth and the width of the entry counter (holds 0 to CAPACITY).
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Stream word widths, padded to whole bytes.
  localparam int IN_W  = 72;
  localparam int OUT_W = 80;

  // Command codes carried in the low bits of an input word.
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_MODIFY  = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One queue entry.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // Comparison results a cell captures against the incoming request.
  typedef struct packed {
    logic match;        // stored value equals the requested value
    logic cell_lt_req;  // stored priority below the requested priority
    logic req_lt_cell;  // requested priority below the stored priority
  } cell_flags_t;

  // Where a cell takes its next contents from.
  typedef enum logic [1:0] {
    SEL_KEEP = 2'd0,
    SEL_NEW  = 2'd1,
    SEL_LO   = 2'd2,
    SEL_HI   = 2'd3
  } sel_t;

endpackage

>>> rtl/sorted_array_priority_queue_core.sv
// Top level of the sorted-array priority queue: control and a chain of entry cells.
//
// The queue holds up to CAPACITY (value, priority) entries in a row of cells,
// cell 0 holding the top entry (greatest priority; a new entry is placed above
// held ones of equal priority). Commands arrive as words on the in_ channel and each
// gives exactly one result word on the out_ channel.
//
// In the accepting cycle every cell compares its entry with the request and
// registers the outcome; in the next cycle every cell picks its new contents
// from itself, the request or a neighbour, all cells at once, and the result
// is written to the output register, whose valid flag drives out_tvalid. No
// new word is taken while a command executes.
//
// Reset empties the queue and drops any pending result; entry contents are
// not cleared, since only held entries are ever read. When the receiver
// stalls, the result is held in the output register and no further word is
// accepted until it has been taken.
module sorted_array_priority_queue_core
  import sapq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Command input
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[1:0], priority_req[33:2], item_value[65:34]
  // Result output
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], out_value[33:2], out_priority[65:34],
                                       // entry_count[72:66]
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  cmd_t             cmd_r;
  entry_t           req_r;
  entry_t           in_req;
  logic             in_acc;

  status_t          res_status_r, res_status_nxt;
  entry_t           res_ent_r, res_ent_nxt;
  logic [CNT_W-1:0] res_count_r;

  entry_t           cell_ent   [CAPACITY];
  cell_flags_t      cell_flags [CAPACITY];
  sel_t             cell_sel   [CAPACITY];

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] mv;       // held entry whose value matches
  logic [CAPACITY-1:0] sfx;      // some match lies further from the top
  logic [CAPACITY-1:0] is_m;     // the match furthest from the top
  logic [CAPACITY:0]   ahead;    // modify: entry ends nearer the top than the target
  logic [CAPACITY-1:0] keep_ins; // insert: entry stays above the new one
  logic                found;

  // Handshakes: one command in flight, output register must be free or being taken.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_req.prio  = in_tdata[33:2];
  assign in_req.value = in_tdata[65:34];

  // Request register, loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_tdata[1:0]);
      req_r <= in_req;
    end
  end

  // The cell chain.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t lo_ent;
    entry_t hi_ent;

    if (k == 0) begin : g_top
      assign lo_ent = cell_ent[k];
    end else begin : g_lo
      assign lo_ent = cell_ent[k-1];
    end
    if (k == CAPACITY - 1) begin : g_bot
      assign hi_ent = cell_ent[k];
    end else begin : g_hi
      assign hi_ent = cell_ent[k+1];
    end

    sapq_cell u_cell (
      .clk    (clk),
      .cap_en (in_acc),
      .req    ((state_r == S_EXEC) ? req_r : in_req),
      .sel    (cell_sel[k]),
      .lo_ent (lo_ent),
      .hi_ent (hi_ent),
      .ent    (cell_ent[k]),
      .flags  (cell_flags[k])
    );

    // Per-cell occupancy and match.
    assign valid[k] = (CNT_W'(k) < count_r);
    assign mv[k]    = valid[k] && cell_flags[k].match;

    // Suffix OR of matches, so the lowest-placed match can be singled out.
    if (k == CAPACITY - 1) begin : g_sfx_end
      assign sfx[k] = 1'b0;
    end else begin : g_sfx
      assign sfx[k] = sfx[k+1] | mv[k+1];
    end
    assign is_m[k] = mv[k] && !sfx[k];

    // Entries above the target pass it on equal priority, those below do not.
    assign ahead[k] = valid[k] && !is_m[k] &&
                      (sfx[k] ? !cell_flags[k].cell_lt_req : cell_flags[k].req_lt_cell);
    assign keep_ins[k] = valid[k] && cell_flags[k].req_lt_cell;

    // Select the source of this cell's next contents.
    always_comb begin
      logic new_here_ins;
      logic new_here_mod;
      new_here_ins = (k == 0) ? 1'b1 : keep_ins[(k == 0) ? 0 : k-1];
      new_here_mod = (k == 0) ? 1'b1 : ahead[(k == 0) ? 0 : k-1];
      cell_sel[k] = SEL_KEEP;
      if (state_r == S_EXEC) begin
        case (cmd_r)
          CMD_INSERT: begin
            if (count_r != CNT_W'(CAPACITY)) begin
              if (keep_ins[k]) cell_sel[k] = SEL_KEEP;
              else if (new_here_ins) cell_sel[k] = SEL_NEW;
              else cell_sel[k] = SEL_LO;
            end
          end
          CMD_EXTRACT: begin
            if (count_r != '0) cell_sel[k] = SEL_HI;
          end
          CMD_PEEK: cell_sel[k] = SEL_KEEP;
          CMD_MODIFY: begin
            if (found) begin
              if (sfx[k]) begin
                // Above the target: make room when the target moves up.
                if (ahead[k]) cell_sel[k] = SEL_KEEP;
                else if (new_here_mod) cell_sel[k] = SEL_NEW;
                else cell_sel[k] = SEL_LO;
              end else if (is_m[k]) begin
                if (ahead[k+1]) cell_sel[k] = SEL_HI;
                else if (new_here_mod) cell_sel[k] = SEL_NEW;
                else cell_sel[k] = SEL_LO;
              end else begin
                // Below the target: close the gap when the target moves down.
                if (ahead[k+1]) cell_sel[k] = SEL_HI;
                else if (ahead[k]) cell_sel[k] = SEL_NEW;
                else cell_sel[k] = SEL_KEEP;
              end
            end
          end
          default: cell_sel[k] = SEL_KEEP;
        endcase
      end
    end
  end

  assign ahead[CAPACITY] = 1'b0;
  assign found = sfx[0] | mv[0];

  // Result and count for the command being executed.
  always_comb begin
    res_status_nxt = ST_OK;
    res_ent_nxt    = '0;
    count_nxt      = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) res_status_nxt = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (count_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_ent_nxt = cell_ent[0];
          if (cmd_r == CMD_EXTRACT) count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_MODIFY: begin
        if (!found) res_status_nxt = ST_NOT_FOUND;
      end
      default: res_status_nxt = ST_OK;
    endcase
  end

  // Sequencer and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC) count_r <= count_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      res_status_r <= res_status_nxt;
      res_ent_r    <= res_ent_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - 2 - 64 - CNT_W)'(0), res_count_r,
                       res_ent_r.prio, res_ent_r.value, res_status_r};

endmodule

>>> rtl/sapq_cell.sv
// One storage cell of the sorted chain: an entry, its compare flags and the load mux.
module sapq_cell
  import sapq_pkg::*;
(
  input  logic        clk,
  input  logic        cap_en,     // capture compare flags against req
  input  entry_t      req,        // request entry, compared and loaded
  input  sel_t        sel,        // source of the next contents
  input  entry_t      lo_ent,     // neighbour one place nearer the top
  input  entry_t      hi_ent,     // neighbour one place further from the top
  output entry_t      ent,
  output cell_flags_t flags
);

  entry_t      ent_r;
  entry_t      ent_nxt;
  cell_flags_t flags_r;
  cell_flags_t flags_nxt;

  // Compare the stored entry against the word being accepted.
  always_comb begin
    flags_nxt.match       = (ent_r.value == req.value);
    flags_nxt.cell_lt_req = (ent_r.prio < req.prio);
    flags_nxt.req_lt_cell = (req.prio < ent_r.prio);
  end

  // Load mux: keep, take the request, or shift from a neighbour.
  always_comb begin
    case (sel)
      SEL_KEEP: ent_nxt = ent_r;
      SEL_NEW:  ent_nxt = req;
      SEL_LO:   ent_nxt = lo_ent;
      SEL_HI:   ent_nxt = hi_ent;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (cap_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign ent   = ent_r;
  assign flags = flags_r;

endmodule

>>> rtl/sapq_checker.sv
// Port-level checks of the priority queue, bound to the top level.
module sapq_checker
  import sapq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // No result is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word pending after reset");

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[66 + CNT_W - 1:66] <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An empty result carries zero data.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_EMPTY |-> out_tdata[65:2] == '0)
    else $error("empty result with non-zero data");

  // One command at a time: no word is taken in the cycle after one is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while a command executes");

endmodule

bind sorted_array_priority_queue_core sapq_checker u_sapq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/sorted_array_priority_queue_core_tb.sv
// Self-checking testbench for the sorted-array priority queue core.
module sorted_array_priority_queue_core_tb
  import sapq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected contents of one result word.
  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic [6:0]         count;
  } queue_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // Shadow copy of the queue, slot 0 lowest priority, slot q_size-1 the top.
  logic signed [31:0] q_vals [CAPACITY];
  logic signed [31:0] q_prios[CAPACITY];
  int                 q_size;

  queue_result_t expected_results[$];
  int            mismatch_count;
  int            sender_idle_pct;
  int            receiver_stall_pct;
  int            hold_cycles;

  sorted_array_priority_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one command to the shadow queue and returns the result it should give.
  function automatic queue_result_t queue_outcome(cmd_t cmd, logic signed [31:0] prio,
                                                  logic signed [31:0] val);
    queue_result_t      r;
    int                 i;
    bit                 found;
    logic signed [31:0] tv;
    logic signed [31:0] tp;
    r.status = ST_OK;
    r.value  = '0;
    r.prio   = '0;
    found    = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (q_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Shift strictly greater priorities up; ties stay below the new entry.
          i = q_size;
          while (i > 0 && prio < q_prios[i-1]) begin
            q_vals[i]  = q_vals[i-1];
            q_prios[i] = q_prios[i-1];
            i--;
          end
          q_vals[i]  = val;
          q_prios[i] = prio;
          q_size++;
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (q_size == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = q_vals[q_size-1];
          r.prio  = q_prios[q_size-1];
          if (cmd == CMD_EXTRACT) q_size--;
        end
      end
      default: begin
        // Lowest-placed matching value gets the new priority, then is moved into place.
        for (i = 0; i < q_size; i++) begin
          if (q_vals[i] == val) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          q_prios[i] = prio;
          while (i > 0 && prio < q_prios[i-1]) begin
            tv = q_vals[i];     tp = q_prios[i];
            q_vals[i] = q_vals[i-1]; q_prios[i] = q_prios[i-1];
            q_vals[i-1] = tv;   q_prios[i-1] = tp;
            i--;
          end
          while (i + 1 < q_size && q_prios[i+1] < prio) begin
            tv = q_vals[i];     tp = q_prios[i];
            q_vals[i] = q_vals[i+1]; q_prios[i] = q_prios[i+1];
            q_vals[i+1] = tv;   q_prios[i+1] = tp;
            i++;
          end
        end
      end
    endcase
    r.count = 7'(q_size);
    return r;
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatch_count < 10) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endfunction

  // Result checker: every word taken is compared with the oldest expectation.
  initial begin
    queue_result_t exp_r;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result word %h", out_tdata));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[1:0] !== exp_r.status)
            note_mismatch($sformatf("status expected %0d got %0d",
                                    exp_r.status, out_tdata[1:0]));
          if (out_tdata[33:2] !== exp_r.value)
            note_mismatch($sformatf("value expected %0d got %0d",
                                    exp_r.value, $signed(out_tdata[33:2])));
          if (out_tdata[65:34] !== exp_r.prio)
            note_mismatch($sformatf("priority expected %0d got %0d",
                                    exp_r.prio, $signed(out_tdata[65:34])));
          if (out_tdata[72:66] !== exp_r.count)
            note_mismatch($sformatf("count expected %0d got %0d",
                                    exp_r.count, out_tdata[72:66]));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_tready  = 1'b0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else begin
        out_tready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Sends one command word; called and returns at a falling edge.
  task automatic send_command(cmd_t cmd, logic signed [31:0] prio, logic signed [31:0] val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {{(IN_W-66){1'b0}}, val, prio, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(queue_outcome(cmd, prio, val));
    @(negedge clk);
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Priorities: many near zero for ties, full range, and the extremes.
  function automatic logic signed [31:0] random_prio();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(8)) - 4;
      8:          return ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default:    return $urandom;
    endcase
  endfunction

  // Values: a small pool gives duplicates, the rest cover every bit.
  function automatic logic signed [31:0] random_value();
    if ($urandom_range(9) < 4) return $urandom_range(15);
    return $urandom;
  endfunction

  // Mostly held values so modify finds something; otherwise usually a miss.
  function automatic logic signed [31:0] modify_target();
    if (q_size > 0 && $urandom_range(9) < 6) return q_vals[$urandom_range(q_size-1)];
    return random_value();
  endfunction

  // Mixed random commands with the given insert and extract weights.
  task automatic run_mixed(int n, int insert_w, int extract_w);
    int pick;
    repeat (n) begin
      pick = $urandom_range(insert_w + extract_w + 30 - 1);
      if (pick < insert_w)
        send_command(CMD_INSERT, random_prio(), random_value());
      else if (pick < insert_w + extract_w)
        send_command(CMD_EXTRACT, random_prio(), random_value());
      else if (pick < insert_w + extract_w + 10)
        send_command(CMD_PEEK, random_prio(), random_value());
      else
        send_command(CMD_MODIFY, random_prio(), modify_target());
    end
  endtask

  // Empty queue, extreme fields, ties, modify in both directions and on duplicates.
  task automatic test_directed();
    set_idling(0, 30);
    send_command(CMD_EXTRACT, 32'sd0, 32'sd0);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    send_command(CMD_MODIFY, 32'sd3, 32'sd0);
    send_command(CMD_INSERT, 32'sh7fffffff, 32'sh80000000);
    send_command(CMD_INSERT, 32'sh80000000, 32'sh7fffffff);
    send_command(CMD_INSERT, 32'sd0, -32'sd1);
    send_command(CMD_INSERT, 32'sd0, 32'sd0);
    send_command(CMD_INSERT, 32'sd0, 32'sd5);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    send_command(CMD_MODIFY, 32'sh80000000, 32'sh80000000);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    send_command(CMD_MODIFY, 32'sd5, -32'sd1);
    send_command(CMD_MODIFY, 32'sd9, 32'sd1234);
    send_command(CMD_INSERT, -32'sd1, 32'sd5);
    send_command(CMD_MODIFY, 32'sd7, 32'sd5);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    repeat (6) send_command(CMD_EXTRACT, 32'sd0, 32'sd0);
    send_command(CMD_EXTRACT, -32'sd1, -32'sd1);
    send_command(CMD_PEEK, -32'sd1, -32'sd1);
    wait_drained();
  endtask

  // Fill to capacity, try to overfill, then drain past empty.
  task automatic test_fill_and_drain();
    set_idling(0, 0);
    while (q_size < CAPACITY) send_command(CMD_INSERT, random_prio(), random_value());
    repeat (3) send_command(CMD_INSERT, random_prio(), random_value());
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    repeat (4) send_command(CMD_MODIFY, random_prio(), modify_target());
    send_command(CMD_INSERT, random_prio(), random_value());
    repeat (CAPACITY + 2) send_command(CMD_EXTRACT, random_prio(), random_value());
    wait_drained();
  endtask

  // Random traffic under one idling pattern, with a fill-heavy and a drain-heavy half.
  task automatic test_random(int sender_pct, int receiver_pct, int n);
    set_idling(sender_pct, receiver_pct);
    run_mixed(n / 2, 55, 15);
    run_mixed(n - n / 2, 20, 40);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_backpressure();
    set_idling(0, 0);
    @(posedge clk);
    hold_cycles = 300;
    @(negedge clk);
    run_mixed(40, 40, 20);
    wait_drained();
  endtask

  // Sender stops mid-traffic until everything is back, then carries on.
  task automatic test_pause();
    set_idling(20, 20);
    run_mixed(30, 40, 20);
    wait_drained();
    repeat (5) @(negedge clk);
    run_mixed(30, 30, 30);
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    q_size    = 0;
    set_idling(0, 0);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_drain();
    test_random(0, 0, 200);
    test_random(58, 0, 200);
    test_random(0, 58, 200);
    test_random(7, 7, 200);
    test_backpressure();
    test_pause();

    // Let any stray word show up before the verdict.
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sapq_pkg.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue_core.sv
rtl/sapq_checker.sv
tb/sv/sorted_array_priority_queue_core_tb.sv
